// ----- rtl/core/b32_pkg.sv -----
// ----------------------------------------------------------------------------
// b32_pkg
// Shared types, constants and the alphabet lookup for the base32 codec.
// ----------------------------------------------------------------------------
package b32_pkg;

  localparam int unsigned SYM_W       = 8;
  localparam int unsigned ACC_W       = 12;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned GROUP_BITS  = 5;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned LETTERS     = 26;
  localparam int unsigned MAX_RES     = 3;
  localparam int unsigned RES_CNT_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SYM_W-1:0] CHAR_A = 8'h61;
  localparam logic [SYM_W-1:0] CHAR_Z = 8'h7a;
  localparam logic [SYM_W-1:0] CHAR_2 = 8'h32;
  localparam logic [SYM_W-1:0] CHAR_7 = 8'h37;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  typedef struct packed {
    logic [MAX_RES-1:0][SYM_W-1:0] syms;
    logic [RES_CNT_W-1:0]          count;
  } job_t;

  function automatic logic [SYM_W-1:0] b32_char(input logic [GROUP_BITS-1:0] v);
    logic [GROUP_BITS-1:0] letters;
    letters = GROUP_BITS'(LETTERS);
    if (v < letters) begin
      return CHAR_A + SYM_W'(v);
    end else begin
      return CHAR_2 + SYM_W'(v - letters);
    end
  endfunction

endpackage

// ----- rtl/core/b32_if.sv -----
// ----------------------------------------------------------------------------
// b32_if
// Valid/ready channels of the base32 codec: symbol input, result output and
// the mode register write.
// ----------------------------------------------------------------------------
interface b32_sym_if import b32_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] in_symbol;
  logic             end_of_string;

  modport source (output valid, output in_symbol, output end_of_string, input ready);
  modport sink   (input valid, input in_symbol, input end_of_string, output ready);
endinterface

interface b32_res_if import b32_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] out_symbol;
  logic             run_last;

  modport source (output valid, output out_symbol, output run_last, input ready);
  modport sink   (input valid, input out_symbol, input run_last, output ready);
endinterface

interface b32_cfg_if import b32_pkg::*; ();
  logic valid;
  logic ready;
  logic decode_mode;

  modport source (output valid, output decode_mode, input ready);
  modport sink   (input valid, input decode_mode, output ready);
endinterface

// ----- rtl/core/b32_front.sv -----
// ----------------------------------------------------------------------------
// b32_front
// Accepts input symbols, updates the bit accumulator and packs the results
// of each request into one job for the queue.
// ----------------------------------------------------------------------------
module b32_front import b32_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  b32_sym_if.sink sym_chan,
  b32_cfg_if.sink cfg_chan,
  output logic  push_valid,
  output job_t  push_job,
  input  logic  push_ready
);

  mode_t            mode;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  logic [ACC_W-1:0]      work_acc;
  logic [CNT_W-1:0]      work_cnt;
  logic [ACC_W-1:0]      keep_mask;
  logic [GROUP_BITS-1:0] dec_val;
  logic                  dec_ok;
  logic                  take;

  assign cfg_chan.ready = 1'b1;
  assign sym_chan.ready = push_ready;
  assign take           = sym_chan.valid && push_ready;
  assign push_valid     = take && (push_job.count != '0);

  always_comb begin
    dec_ok  = 1'b1;
    dec_val = '0;
    if (sym_chan.in_symbol inside {[CHAR_A:CHAR_Z]}) begin
      dec_val = GROUP_BITS'(sym_chan.in_symbol - CHAR_A);
    end else if (sym_chan.in_symbol inside {[CHAR_2:CHAR_7]}) begin
      dec_val = GROUP_BITS'(sym_chan.in_symbol - CHAR_2) + GROUP_BITS'(LETTERS);
    end else begin
      dec_ok = 1'b0;
    end
  end

  always_comb begin
    push_job  = '0;
    work_acc  = acc;
    work_cnt  = cnt;
    keep_mask = '0;
    if (mode == MODE_ENCODE) begin
      work_acc = {acc[3:0], sym_chan.in_symbol};
      work_cnt = cnt + CNT_W'(BYTE_BITS) - CNT_W'(GROUP_BITS);
      push_job.syms[0]  = b32_char(GROUP_BITS'(work_acc >> work_cnt));
      push_job.count    = RES_CNT_W'(1);
      if (work_cnt >= CNT_W'(GROUP_BITS)) begin
        work_cnt = work_cnt - CNT_W'(GROUP_BITS);
        push_job.syms[1] = b32_char(GROUP_BITS'(work_acc >> work_cnt));
        push_job.count   = RES_CNT_W'(2);
      end
      keep_mask = (ACC_W'(1) << work_cnt) - ACC_W'(1);
      work_acc  = work_acc & keep_mask;
      if (sym_chan.end_of_string && (work_cnt != '0)) begin
        push_job.syms[push_job.count] =
          b32_char(GROUP_BITS'(work_acc << (CNT_W'(GROUP_BITS) - work_cnt)));
        push_job.count = push_job.count + RES_CNT_W'(1);
      end
    end else begin
      if (dec_ok) begin
        work_acc = {acc[6:0], dec_val};
        work_cnt = cnt + CNT_W'(GROUP_BITS);
      end
      if (work_cnt >= CNT_W'(BYTE_BITS)) begin
        work_cnt = work_cnt - CNT_W'(BYTE_BITS);
        push_job.syms[0] = SYM_W'(work_acc >> work_cnt);
        push_job.count   = RES_CNT_W'(1);
        keep_mask = (ACC_W'(1) << work_cnt) - ACC_W'(1);
        work_acc  = work_acc & keep_mask;
      end
    end
  end

  always_comb begin
    acc_next = acc;
    cnt_next = cnt;
    if (cfg_chan.valid) begin
      acc_next = '0;
      cnt_next = '0;
    end else if (take) begin
      if (sym_chan.end_of_string) begin
        acc_next = '0;
        cnt_next = '0;
      end else begin
        acc_next = work_acc;
        cnt_next = work_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
      acc  <= '0;
      cnt  <= '0;
    end else begin
      if (cfg_chan.valid) begin
        mode <= mode_t'(cfg_chan.decode_mode);
      end
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

endmodule

// ----- rtl/core/b32_queue.sv -----
// ----------------------------------------------------------------------------
// b32_queue
// Small first-in first-out job queue between the front and back parts.
// ----------------------------------------------------------------------------
module b32_queue import b32_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  job_t push_job,
  output logic push_ready,
  output logic pop_valid,
  output job_t pop_job,
  input  logic pop_ready
);

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  job_t              slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != FILL_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/b32_back.sv -----
// ----------------------------------------------------------------------------
// b32_back
// Takes jobs from the queue and, while the receiver is ready, sends their
// symbols one per cycle through a registered output, marking each job's end.
// ----------------------------------------------------------------------------
module b32_back import b32_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic pop_valid,
  input  job_t pop_job,
  output logic pop_ready,
  b32_res_if.source res_chan
);

  job_t                 cur;
  logic                 cur_valid;
  logic [RES_CNT_W-1:0] idx;
  logic                 cur_last;
  logic                 load_out;
  logic                 out_valid;
  logic [SYM_W-1:0]     out_symbol;
  logic                 run_last;

  assign cur_last  = (idx == RES_CNT_W'(cur.count - RES_CNT_W'(1)));
  assign load_out  = cur_valid && (!out_valid || res_chan.ready);
  assign pop_ready = !cur_valid || (load_out && cur_last);

  assign res_chan.valid      = out_valid;
  assign res_chan.out_symbol = out_symbol;
  assign res_chan.run_last   = run_last;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_symbol <= cur.syms[idx];
      run_last   <= cur_last;
    end
    if (pop_valid && pop_ready) begin
      cur <= pop_job;
      idx <= '0;
    end else if (load_out) begin
      idx <= idx + RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res_chan.ready) begin
        out_valid <= 1'b0;
      end
      if (pop_ready) begin
        cur_valid <= pop_valid;
      end
    end
  end

endmodule

// ----- rtl/core/base32_stream_codec_unit.sv -----
// ----------------------------------------------------------------------------
// base32_stream_codec_unit
// Streaming base32 encoder and decoder, lower-case alphabet, no padding.
// ----------------------------------------------------------------------------
// The sym_chan channel takes one symbol request per accepted handshake: a raw
// byte when encoding or a character when decoding, with end_of_string on the
// final symbol of a string. Each request yields zero to three results on
// res_chan, the last of them flagged by run_last. Invalid characters in
// decode mode yield nothing. The cfg_chan channel writes decode_mode and
// clears any pending bits; it is always ready. The user must write cfg_chan
// only while the block is idle; the block itself does not enforce this.
// Results pass through the job queue, the job register and the output
// register. Requests are accepted back to back while the job queue has
// room; results leave at one per cycle through the output register while
// the receiver is ready, so the sustained input rate is set by the result
// count per request. When the receiver stalls, the output register holds,
// the queue fills and sym_chan.ready drops. Reset selects encode mode,
// clears the accumulator, empties the queue and drops all valid flags.
// ----------------------------------------------------------------------------
module base32_stream_codec_unit import b32_pkg::*; #(
  parameter int unsigned Q_DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  b32_sym_if.sink   sym_chan,
  b32_res_if.source res_chan,
  b32_cfg_if.sink   cfg_chan
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  b32_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sym_chan   (sym_chan),
    .cfg_chan   (cfg_chan),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  b32_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  b32_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop_ready (pop_ready),
    .res_chan  (res_chan)
  );

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base32 stream codec. A scoreboard tracks the
// codec state, predicts the characters or bytes that each accepted request
// produces and compares them in order with the results on the output
// channel. Directed strings open the run, then random strings follow in
// phases of encode or decode, most with random idling on both sides.
// ----------------------------------------------------------------------------
import b32_pkg::*;

class codec_scoreboard;
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } result_t;

  result_t          expected_q[$];
  mode_t            mode;
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  string            alphabet;
  int               errors;
  int               checked;

  function new();
    alphabet = "abcdefghijklmnopqrstuvwxyz234567";
    mode     = MODE_ENCODE;
    acc      = '0;
    cnt      = '0;
    errors   = 0;
    checked  = 0;
  endfunction

  function logic [SYM_W-1:0] symbol_for(logic [GROUP_BITS-1:0] v);
    return SYM_W'(alphabet[v]);
  endfunction

  function void write_mode(mode_t m);
    mode = m;
    acc  = '0;
    cnt  = '0;
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction

  function void note_request(logic [SYM_W-1:0] sym, logic eos);
    logic [SYM_W-1:0]      outs [MAX_RES];
    logic [GROUP_BITS-1:0] v;
    logic                  ok;
    int                    n;
    result_t               r;
    n  = 0;
    ok = 1'b1;
    v  = '0;
    if (mode == MODE_ENCODE) begin
      acc = (acc << BYTE_BITS) | ACC_W'(sym);
      cnt = cnt + CNT_W'(BYTE_BITS);
      while (cnt >= GROUP_BITS) begin
        cnt     = cnt - CNT_W'(GROUP_BITS);
        outs[n] = symbol_for(GROUP_BITS'(acc >> cnt));
        n       = n + 1;
      end
      acc = acc & ((ACC_W'(1) << cnt) - ACC_W'(1));
      if (eos && cnt > 0) begin
        outs[n] = symbol_for(GROUP_BITS'(acc << (GROUP_BITS - cnt)));
        n       = n + 1;
      end
    end else begin
      if (sym >= CHAR_A && sym <= CHAR_Z) begin
        v = GROUP_BITS'(sym - CHAR_A);
      end else if (sym >= CHAR_2 && sym <= CHAR_7) begin
        v = GROUP_BITS'(sym - CHAR_2 + LETTERS);
      end else begin
        ok = 1'b0;
      end
      if (ok) begin
        acc = (acc << GROUP_BITS) | ACC_W'(v);
        cnt = cnt + CNT_W'(GROUP_BITS);
      end
      if (cnt >= BYTE_BITS) begin
        cnt     = cnt - CNT_W'(BYTE_BITS);
        outs[n] = SYM_W'(acc >> cnt);
        n       = n + 1;
        acc     = acc & ((ACC_W'(1) << cnt) - ACC_W'(1));
      end
    end
    if (eos) begin
      acc = '0;
      cnt = '0;
    end
    for (int i = 0; i < n; i++) begin
      r.sym  = outs[i];
      r.last = (i == n - 1);
      expected_q.push_back(r);
    end
  endfunction

  function void check_result(logic [SYM_W-1:0] sym, logic last);
    result_t e;
    if (expected_q.size() == 0) begin
      errors = errors + 1;
      $display("%0t: unexpected result out_symbol=%h run_last=%b", $time, sym, last);
      return;
    end
    e       = expected_q.pop_front();
    checked = checked + 1;
    if (sym !== e.sym) begin
      errors = errors + 1;
      $display("%0t: out_symbol expected %h actual %h", $time, e.sym, sym);
    end
    if (last !== e.last) begin
      errors = errors + 1;
      $display("%0t: run_last expected %b actual %b", $time, e.last, last);
    end
  endfunction
endclass

module tb_top;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 8;
  localparam int PHASE_ITEMS  = 40;
  localparam int HOLD_CYCLES  = 200;

  logic clk = 1'b0;
  logic rst;

  b32_sym_if sym_chan ();
  b32_res_if res_chan ();
  b32_cfg_if cfg_chan ();

  codec_scoreboard sb = new();

  int requests    = 0;
  int results     = 0;
  int writes      = 0;
  int rx_gap      = 0;
  int rx_hold     = 0;
  int idle_cycles = 0;
  bit tx_eager    = 1'b0;
  bit rx_eager    = 1'b0;

  base32_stream_codec_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .sym_chan (sym_chan),
    .res_chan (res_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol(mode_t m);
    if (m == MODE_DECODE && $urandom_range(0, 99) < 88) begin
      return sb.symbol_for(GROUP_BITS'($urandom_range(0, 31)));
    end
    return SYM_W'($urandom_range(0, 255));
  endfunction

  task automatic send_symbol(input logic [SYM_W-1:0] s, input logic eos);
    int gap;
    gap = tx_eager ? 0 : idle_len();
    if (gap > 0) begin
      sym_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sym_chan.valid         <= 1'b1;
    sym_chan.in_symbol     <= s;
    sym_chan.end_of_string <= eos;
    @(posedge clk);
    while (!sym_chan.ready) @(posedge clk);
    sb.note_request(s, eos);
    requests = requests + 1;
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) begin
      send_symbol(SYM_W'(s[i]), close && (i == s.len() - 1));
    end
  endtask

  // Mode writes only go out once the codec has drained and settled.
  task automatic write_mode(input mode_t m);
    sym_chan.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_chan.valid       <= 1'b1;
    cfg_chan.decode_mode <= m;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    sb.write_mode(m);
    writes = writes + 1;
    cfg_chan.valid <= 1'b0;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (res_chan.valid && res_chan.ready) begin
        sb.check_result(res_chan.out_symbol, res_chan.run_last);
        results = results + 1;
      end
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        res_chan.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap = rx_gap - 1;
        res_chan.ready <= 1'b0;
      end else begin
        res_chan.ready <= 1'b1;
        rx_gap = rx_eager ? 0 : idle_len();
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((sym_chan.valid && sym_chan.ready) || (res_chan.valid && res_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results still expected",
                 $time, STALL_LIMIT, sb.outstanding());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    mode_t      plan [8];
    int         count;
    int         len;
    logic [7:0] s;
    plan = '{MODE_DECODE, MODE_ENCODE, MODE_ENCODE, MODE_DECODE,
             MODE_DECODE, MODE_ENCODE, MODE_DECODE, MODE_ENCODE};
    rst                    <= 1'b1;
    sym_chan.valid         <= 1'b0;
    sym_chan.in_symbol     <= '0;
    sym_chan.end_of_string <= 1'b0;
    res_chan.ready         <= 1'b0;
    cfg_chan.valid         <= 1'b0;
    cfg_chan.decode_mode   <= MODE_ENCODE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Encode straight out of reset, then the decode edge cases.
    send_symbol(8'h00, 1'b1);
    send_symbol(8'hff, 1'b1);
    send_text("fooba", 1'b1);
    write_mode(MODE_DECODE);
    send_text("mzxw6ytb", 1'b1);
    send_symbol(8'h60, 1'b0);
    send_symbol(8'h7b, 1'b0);
    send_symbol(8'h31, 1'b0);
    send_symbol(8'h38, 1'b0);
    send_symbol(8'h41, 1'b0);
    send_symbol(8'hff, 1'b0);
    send_symbol(CHAR_2, 1'b0);
    send_symbol(CHAR_7, 1'b1);
    send_symbol(CHAR_A, 1'b0);
    send_symbol(8'h00, 1'b1);

    // Random strings; a phase may end inside a string, so the next mode
    // write also has to discard pending bits.
    for (int ph = 0; ph < 8; ph++) begin
      write_mode(plan[ph]);
      tx_eager = (ph == 2) || (ph == 6);
      rx_eager = (ph == 5);
      if (ph == 2) begin
        rx_hold = HOLD_CYCLES;
      end
      count = 0;
      while (count < PHASE_ITEMS) begin
        len = $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(9, 20);
        end
        for (int i = 0; i < len && count < PHASE_ITEMS; i++) begin
          s = pick_symbol(plan[ph]);
          send_symbol(s, i == len - 1);
          count = count + 1;
        end
      end
    end

    sym_chan.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4 * SETTLE) @(posedge clk);
    $display("Run covered %0d requests and %0d checked results over %0d mode writes,",
             requests, sb.checked, writes);
    $display("both modes, open and closed strings, invalid characters and a long hold-off.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
